// ----- sv/assert_macros.svh -----
// assertion macros used by the top module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge while out of reset
`define FIC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// checked on every clock edge, also during reset
`define FIC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// ----- sv/fic_pkg.sv -----
// constants and helpers of the fenwick inversion counter
`default_nettype none

package fic_pkg;

    localparam int TOTAL_W = 27;
    localparam int COUNT_W = 11;
    localparam int RANK_W  = 11;
    localparam int SIZE_W  = 11;

    localparam int MAX_ELEMENTS_DEF = 1024;

    localparam logic [TOTAL_W-1:0] TOTAL_MOD  = 27'd99999997;
    localparam logic [SIZE_W-1:0]  SIZE_RESET = 11'd1024;

    typedef logic [TOTAL_W-1:0] total_t;
    typedef logic [COUNT_W-1:0] count_t;

    // a + b mod TOTAL_MOD, both operands already below the modulus
    function automatic total_t add_mod(input total_t a, input total_t b);
        logic [TOTAL_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= {1'b0, TOTAL_MOD}) begin
            sum = sum - {1'b0, TOTAL_MOD};
        end
        return sum[TOTAL_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- sv/fenwick_inversion_counter_top.sv -----
// fenwick tree inversion counter: sequencer, running total and result register
// invalid rank: straight to the result; valid rank r: prefix query walk down from r, the total
//   update, an upward insert walk from r + 1 within the size, then the result register
// one item at a time: no new beat is taken until the result of the current one is loaded
// reset and the result of each tlast beat start a clearing pass over entries 0..MAX_ELEMENTS, no beat taken
`default_nettype none

module fenwick_inversion_counter_top
    import fic_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration write: size_in_use
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [SIZE_W-1:0] cfg_data,
    // input beats
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [10:0] rank_value, [15:11] zero
    input  wire logic        s_tlast,   // last_item
    // result beats
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [26:0] running_total, [31:27] zero
    output logic             m_tuser,   // rank_error
    output logic             m_tlast    // last_result
);

`include "assert_macros.svh"

    // tree address covers positions 0..MAX_ELEMENTS, entry 0 unused
    localparam int DEPTH = MAX_ELEMENTS + 1;
    localparam int AW    = $clog2(DEPTH);
    // walk position width: insert walk may step past the size up to twice it
    localparam int PW    = $clog2(MAX_ELEMENTS + 1) + 1;
    localparam int WW    = (PW > RANK_W + 1) ? PW : RANK_W + 1;

    // sequencer states
    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_QUERY  = 3'd2;
    localparam logic [2:0] ST_SUM    = 3'd3;
    localparam logic [2:0] ST_INSERT = 3'd4;
    localparam logic [2:0] ST_OUT    = 3'd5;

    // control registers
    logic [2:0]        state_reg,    state_next;
    logic [SIZE_W-1:0] cfg_size_reg, cfg_size_next;
    logic [AW-1:0]     clr_addr_reg, clr_addr_next;
    logic              pend_reg,     pend_next;
    logic              m_tvalid_reg, m_tvalid_next;
    total_t            total_reg,    total_next;

    // payload registers
    logic [WW-1:0]     qpos_reg,     qpos_next;
    logic [WW-1:0]     ipos_reg,     ipos_next;
    logic [AW-1:0]     iaddr_reg,    iaddr_next;
    total_t            acc_reg,      acc_next;
    logic [RANK_W-1:0] rank_reg,     rank_next;
    logic              last_reg,     last_next;
    logic              err_reg,      err_next;
    total_t            m_total_reg,  m_total_next;
    logic              m_err_reg,    m_err_next;
    logic              m_last_reg,   m_last_next;

    // tree memory ports
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    count_t            ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    count_t            ram_rdata;

    logic [WW-1:0]     size_eff;
    logic [WW-1:0]     rank_in;
    logic              rank_bad;
    logic              ins_ok;
    logic              out_load;

    fic_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (DEPTH)
    ) u_tree (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // effective size clamps the size register to MAX_ELEMENTS
    assign size_eff = (WW'(cfg_size_reg) > WW'(MAX_ELEMENTS)) ? WW'(MAX_ELEMENTS)
                                                              : WW'(cfg_size_reg);

    assign rank_in  = WW'(s_tdata[RANK_W-1:0]);
    assign rank_bad = (rank_in == '0) || (rank_in > size_eff);
    assign ins_ok   = (ipos_reg != '0) && (ipos_reg <= size_eff);

    // result register frees up when empty or taken this cycle
    assign out_load = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {{(32 - TOTAL_W){1'b0}}, m_total_reg};
    assign m_tuser   = m_err_reg;
    assign m_tlast   = m_last_reg;

    always_comb begin
        state_next    = state_reg;
        cfg_size_next = cfg_size_reg;
        clr_addr_next = clr_addr_reg;
        pend_next     = 1'b0;
        total_next    = total_reg;
        qpos_next     = qpos_reg;
        ipos_next     = ipos_reg;
        iaddr_next    = iaddr_reg;
        acc_next      = acc_reg;
        rank_next     = rank_reg;
        last_next     = last_reg;
        err_next      = err_reg;
        m_total_next  = m_total_reg;
        m_err_next    = m_err_reg;
        m_last_next   = m_last_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        ram_we    = 1'b0;
        ram_waddr = clr_addr_reg;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = qpos_reg[AW-1:0];

        if (cfg_valid) begin
            cfg_size_next = cfg_data;
        end

        case (state_reg)
            ST_CLEAR: begin
                ram_we = 1'b1;
                if (clr_addr_reg == AW'(MAX_ELEMENTS)) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_addr_next = clr_addr_reg + AW'(1);
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    rank_next = s_tdata[RANK_W-1:0];
                    last_next = s_tlast;
                    err_next  = rank_bad;
                    qpos_next = rank_in;
                    acc_next  = '0;
                    state_next = rank_bad ? ST_OUT : ST_QUERY;
                end
            end
            ST_QUERY: begin
                // prefix walk downward, one read issued per cycle
                if (qpos_reg != '0) begin
                    ram_re    = 1'b1;
                    qpos_next = qpos_reg - (qpos_reg & (~qpos_reg + WW'(1)));
                    pend_next = 1'b1;
                end
                if (pend_reg) begin
                    acc_next = add_mod(acc_reg, TOTAL_W'(ram_rdata));
                end
                if (qpos_reg == '0 && !pend_reg) begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                total_next = add_mod(total_reg, acc_reg);
                ipos_next  = WW'(rank_reg) + WW'(1);
                state_next = ST_INSERT;
            end
            ST_INSERT: begin
                // upward walk: write back the entry read last cycle, read the next one
                ram_raddr = ipos_reg[AW-1:0];
                ram_waddr = iaddr_reg;
                ram_wdata = ram_rdata + COUNT_W'(1);
                ram_we    = pend_reg;
                if (ins_ok) begin
                    ram_re     = 1'b1;
                    iaddr_next = ipos_reg[AW-1:0];
                    ipos_next  = ipos_reg + (ipos_reg & (~ipos_reg + WW'(1)));
                    pend_next  = 1'b1;
                end
                if (!ins_ok && !pend_reg) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    m_tvalid_next = 1'b1;
                    m_total_next  = total_reg;
                    m_err_next    = err_reg;
                    m_last_next   = last_reg;
                    if (last_reg) begin
                        total_next    = '0;
                        clr_addr_next = '0;
                        state_next    = ST_CLEAR;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            cfg_size_reg <= SIZE_RESET;
            clr_addr_reg <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            total_reg    <= '0;
        end else begin
            state_reg    <= state_next;
            cfg_size_reg <= cfg_size_next;
            clr_addr_reg <= clr_addr_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
            total_reg    <= total_next;
        end
    end

    always_ff @(posedge aclk) begin
        qpos_reg    <= qpos_next;
        ipos_reg    <= ipos_next;
        iaddr_reg   <= iaddr_next;
        acc_reg     <= acc_next;
        rank_reg    <= rank_next;
        last_reg    <= last_next;
        err_reg     <= err_next;
        m_total_reg <= m_total_next;
        m_err_reg   <= m_err_next;
        m_last_reg  <= m_last_next;
    end

    // read and write of the tree never meet on one entry, so no forwarding is needed
    `FIC_ASSERT(a_no_rw_collision, (ram_we && ram_re) |-> (ram_waddr != ram_raddr), "tree read and write hit the same entry")
    // a new result only comes out of the result state
    `FIC_ASSERT(a_result_source, $rose(m_tvalid_reg) |-> ($past(state_reg) == ST_OUT), "result beat raised outside the result state")
    // the result of a last item is followed by a cleared total and a clearing pass
    `FIC_ASSERT(a_last_clears, (out_load && last_reg) |=> (total_reg == '0 && state_reg == ST_CLEAR), "last item did not clear the state")
    // reset always starts the clearing pass
    `FIC_ASSERT_ALWAYS(a_reset_clears, !aresetn |=> (state_reg == ST_CLEAR && !m_tvalid_reg), "reset did not start the clearing pass")

endmodule

`default_nettype wire

// ----- sv/fic_ram.sv -----
// generic simple dual port ram with registered read
`default_nettype none

module fic_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1025
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire
